// File: hdl/calendar_day_offset_adder_unit_defines.svh
`ifndef CALENDAR_DAY_OFFSET_ADDER_UNIT_DEFINES_SVH
`define CALENDAR_DAY_OFFSET_ADDER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CDOA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CDOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cdoa_pkg.sv
package cdoa_pkg;

  localparam int CDOA_OFFSET_BITS = 16;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WDAY_W  = 3;

  localparam int YEAR_MIN = 1;
  localparam int YEAR_MAX = 9999;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd5;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd8;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd10;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd11;

  localparam int STEP_W = 3;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE     = 3'd0;
  localparam step_t STEP_LOW_CHK  = 3'd1;
  localparam step_t STEP_PREV     = 3'd2;
  localparam step_t STEP_ADD_LEN  = 3'd3;
  localparam step_t STEP_HIGH_CHK = 3'd4;
  localparam step_t STEP_SUB_LEN  = 3'd5;
  localparam step_t STEP_SPARE    = 3'd6;
  localparam step_t STEP_FINISH   = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_PREV,
    OP_ADD_LEN,
    OP_SUB_LEN,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_NOT_LOW,
    COND_NOT_HIGH,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctl_word_t;

  function automatic ctl_word_t ucode(input step_t pc);
    ctl_word_t w;
    unique case (pc)
      STEP_IDLE:     w = '{op: OP_LOAD,    cond: COND_NO_IN,    target: STEP_IDLE};
      STEP_LOW_CHK:  w = '{op: OP_NOP,     cond: COND_NOT_LOW,  target: STEP_HIGH_CHK};
      STEP_PREV:     w = '{op: OP_PREV,    cond: COND_NEVER,    target: STEP_IDLE};
      STEP_ADD_LEN:  w = '{op: OP_ADD_LEN, cond: COND_ALWAYS,   target: STEP_LOW_CHK};
      STEP_HIGH_CHK: w = '{op: OP_NOP,     cond: COND_NOT_HIGH, target: STEP_FINISH};
      STEP_SUB_LEN:  w = '{op: OP_SUB_LEN, cond: COND_ALWAYS,   target: STEP_HIGH_CHK};
      STEP_SPARE:    w = '{op: OP_NOP,     cond: COND_ALWAYS,   target: STEP_IDLE};
      STEP_FINISH:   w = '{op: OP_FINISH,  cond: COND_OUT_BUSY, target: STEP_FINISH};
      default:       w = '{op: OP_NOP,     cond: COND_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] idx,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (idx) inside
      MON_FEB:                            len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default:                            len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [WDAY_W-1:0] mod7(input logic [7:0] x);
    logic [5:0] a;
    logic [3:0] b;
    logic [3:0] c;
    a = 6'(x[7:3]) + 6'(x[2:0]);
    b = 4'(a[5:3]) + 4'(a[2:0]);
    c = 4'(b[3]) + 4'(b[2:0]);
    if (c >= 4'd7) begin
      c = c - 4'd7;
    end
    return c[2:0];
  endfunction

endpackage

// File: hdl/calendar_day_offset_adder_unit.sv
// Channel  Handshake             Beat contents
// in       in_valid / in_ready   start_year, start_month, start_day, start_weekday, day_offset
// out      out_valid / out_ready new_year, new_month, new_day, new_weekday, out_of_range
//
// Each beat walks the date one month at a time: backward (low check, previous month,
// add its length) or forward (high check, subtract the length, next month), and then
// waits at the finish step for as long as the output register still holds a result.
// Reset (rst, synchronous) returns the step counter to idle and empties the output.
// A new input beat is taken while the previous result still waits in the output register.
`include "calendar_day_offset_adder_unit_defines.svh"

module calendar_day_offset_adder_unit #(
  parameter int OFFSET_BITS = cdoa_pkg::CDOA_OFFSET_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cdoa_pkg::YEAR_W-1:0]       start_year,
  input  logic [cdoa_pkg::MONTH_W-1:0]      start_month,
  input  logic [cdoa_pkg::DAY_W-1:0]        start_day,
  input  logic [cdoa_pkg::WDAY_W-1:0]       start_weekday,
  input  logic signed [OFFSET_BITS-1:0]     day_offset,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cdoa_pkg::YEAR_W-1:0]       new_year,
  output logic [cdoa_pkg::MONTH_W-1:0]      new_month,
  output logic [cdoa_pkg::DAY_W-1:0]        new_day,
  output logic [cdoa_pkg::WDAY_W-1:0]       new_weekday,
  output logic                              out_of_range
);
  import cdoa_pkg::*;

  localparam int YW      = ((OFFSET_BITS > YEAR_W) ? OFFSET_BITS : YEAR_W) + 2;
  localparam int DW      = OFFSET_BITS + 2;
  localparam int NCH     = (OFFSET_BITS + 2) / 3;
  localparam int OPW     = NCH * 3;
  localparam int NEG_ADJ = 7 - (1 << (OFFSET_BITS % 3));

  step_t                pc;
  step_t                pc_next;
  ctl_word_t            ctl;
  logic                 cond_true;

  logic signed [YW-1:0] year;
  logic [MONTH_W-1:0]   midx;
  logic signed [DW-1:0] day;
  logic [7:0]           wsum;

  logic [MONTH_W-1:0]   midx_in;
  logic [OPW-1:0]       off_pad;
  logic [7:0]           csum;
  logic [7:0]           wsum_in;
  logic signed [DW-1:0] day_in;

  logic                 leap;
  logic [DAY_W-1:0]     mlen;
  logic                 day_low;
  logic                 day_high;
  logic                 out_busy;
  logic                 in_fire;
  logic                 finish_fire;

  assign ctl         = ucode(pc);
  assign in_ready    = (ctl.op == OP_LOAD);
  assign in_fire     = in_valid && in_ready;
  assign out_busy    = out_valid && !out_ready;
  assign finish_fire = (ctl.op == OP_FINISH) && !out_busy;

  assign leap     = (year > $signed(YW'(0))) && (year[1:0] == 2'b00);
  assign mlen     = month_len(midx, leap);
  assign day_low  = day < $signed(DW'(1));
  assign day_high = day > $signed({{(DW-DAY_W){1'b0}}, mlen});

  always_comb begin
    if (start_month == 4'd0) begin
      midx_in = MON_DEC;
    end else if (start_month > 4'd12) begin
      midx_in = start_month - 4'd13;
    end else begin
      midx_in = start_month - 4'd1;
    end
    off_pad = OPW'($unsigned(day_offset));
    csum    = '0;
    for (int i = 0; i < NCH; i++) begin
      csum = csum + 8'(off_pad[3*i +: 3]);
    end
    wsum_in = csum + 8'(start_weekday) + 8'd6
            + (day_offset[OFFSET_BITS-1] ? 8'(NEG_ADJ) : 8'd0);
    day_in  = $signed({{(DW-DAY_W){1'b0}}, start_day}) + DW'(day_offset);
  end

  always_comb begin
    unique case (ctl.cond)
      COND_NEVER:    cond_true = 1'b0;
      COND_ALWAYS:   cond_true = 1'b1;
      COND_NO_IN:    cond_true = !in_valid;
      COND_NOT_LOW:  cond_true = !day_low;
      COND_NOT_HIGH: cond_true = !day_high;
      COND_OUT_BUSY: cond_true = out_busy;
      default:       cond_true = 1'b1;
    endcase
    pc_next = cond_true ? ctl.target : pc + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= STEP_IDLE;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (finish_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        if (in_valid) begin
          year <= $signed(YW'(start_year));
          midx <= midx_in;
          day  <= day_in;
          wsum <= wsum_in;
        end
      end
      OP_PREV: begin
        if (midx == MON_JAN) begin
          midx <= MON_DEC;
          year <= year - YW'(1);
        end else begin
          midx <= midx - 4'd1;
        end
      end
      OP_ADD_LEN: begin
        day <= day + $signed({{(DW-DAY_W){1'b0}}, mlen});
      end
      OP_SUB_LEN: begin
        day <= day - $signed({{(DW-DAY_W){1'b0}}, mlen});
        if (midx == MON_DEC) begin
          midx <= MON_JAN;
          year <= year + YW'(1);
        end else begin
          midx <= midx + 4'd1;
        end
      end
      OP_FINISH: begin
        if (!out_busy) begin
          if (year < $signed(YW'(YEAR_MIN))) begin
            new_year     <= YEAR_W'(YEAR_MIN);
            out_of_range <= 1'b1;
          end else if (year > $signed(YW'(YEAR_MAX))) begin
            new_year     <= YEAR_W'(YEAR_MAX);
            out_of_range <= 1'b1;
          end else begin
            new_year     <= year[YEAR_W-1:0];
            out_of_range <= 1'b0;
          end
          new_month   <= midx + 4'd1;
          new_day     <= day[DAY_W-1:0];
          new_weekday <= mod7(wsum) + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  `CDOA_ASSERT_NOW(a_rise_at_finish, $rose(out_valid), $past(pc) == STEP_FINISH, "result without finish step")
  `CDOA_ASSERT_NEXT(a_load_then_check, in_fire, pc == STEP_LOW_CHK, "walk did not start after load")
  `CDOA_ASSERT_NOW(a_fields_legal, out_valid, (new_month >= 4'd1) && (new_month <= 4'd12) && (new_weekday != 3'd0) && (new_day != 5'd0), "illegal date fields")
  `CDOA_ASSERT_NOW(a_year_legal, out_valid, (new_year >= YEAR_W'(YEAR_MIN)) && (new_year <= YEAR_W'(YEAR_MAX)), "year outside saturation range")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cdoa_pkg::*;

  localparam int OFF_W = CDOA_OFFSET_BITS;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  weekday;
    logic               out_of_range;
  } shifted_date_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [YEAR_W-1:0]        start_year;
  logic [MONTH_W-1:0]       start_month;
  logic [DAY_W-1:0]         start_day;
  logic [WDAY_W-1:0]        start_weekday;
  logic signed [OFF_W-1:0]  day_offset;
  logic                     out_valid;
  logic                     out_ready;
  logic [YEAR_W-1:0]        new_year;
  logic [MONTH_W-1:0]       new_month;
  logic [DAY_W-1:0]         new_day;
  logic [WDAY_W-1:0]        new_weekday;
  logic                     out_of_range;

  shifted_date_t pending_dates[$];
  int            mismatch_count;
  bit            steady;

  calendar_day_offset_adder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .start_weekday(start_weekday),
    .day_offset   (day_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .new_year     (new_year),
    .new_month    (new_month),
    .new_day      (new_day),
    .new_weekday  (new_weekday),
    .out_of_range (out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // month index 0..11; no century rule, non-positive years never leap
  function automatic int days_in_month(input int mo, input int yr);
    int len;
    case (mo) inside
      MON_FEB:                            len = (yr > 0 && yr % 4 == 0) ? 29 : 28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 30;
      default:                            len = 31;
    endcase
    return len;
  endfunction

  function automatic shifted_date_t shift_date(input logic [YEAR_W-1:0] y_in,
                                               input logic [MONTH_W-1:0] m_in,
                                               input logic [DAY_W-1:0] d_in,
                                               input logic [WDAY_W-1:0] w_in,
                                               input logic signed [OFF_W-1:0] off_in);
    int yr;
    int mo;
    int dy;
    int wk;
    int off;
    shifted_date_t r;
    yr  = y_in;
    dy  = d_in;
    wk  = w_in;
    off = off_in;
    if (m_in == 0) begin
      mo = MON_DEC;
    end else if (m_in > 12) begin
      mo = int'(m_in) - 13;
    end else begin
      mo = int'(m_in) - 1;
    end
    wk = (wk - 1 + off) % 7;
    if (wk < 0) begin
      wk += 7;
    end
    dy += off;
    while (dy < 1) begin
      mo--;
      if (mo < int'(MON_JAN)) begin
        mo = MON_DEC;
        yr--;
      end
      dy += days_in_month(mo, yr);
    end
    while (dy > days_in_month(mo, yr)) begin
      dy -= days_in_month(mo, yr);
      mo++;
      if (mo > int'(MON_DEC)) begin
        mo = MON_JAN;
        yr++;
      end
    end
    r.out_of_range = 1'b0;
    if (yr < YEAR_MIN) begin
      yr = YEAR_MIN;
      r.out_of_range = 1'b1;
    end else if (yr > YEAR_MAX) begin
      yr = YEAR_MAX;
      r.out_of_range = 1'b1;
    end
    r.year    = yr[YEAR_W-1:0];
    r.month   = 4'(mo + 1);
    r.day     = dy[DAY_W-1:0];
    r.weekday = 3'(wk + 1);
    return r;
  endfunction

  function automatic logic signed [OFF_W-1:0] draw_offset();
    int pick;
    int mag;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      mag = $urandom_range(0, 120);
      return OFF_W'(mag - 60);
    end else if (pick < 85) begin
      mag = $urandom_range(0, 1600);
      return OFF_W'(mag - 800);
    end else if (pick < 96) begin
      mag = $urandom_range(0, 10000);
      return OFF_W'(mag - 5000);
    end
    return OFF_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                           input logic [DAY_W-1:0] d, input logic [WDAY_W-1:0] w,
                           input logic signed [OFF_W-1:0] off);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    start_year    <= y;
    start_month   <= m;
    start_day     <= d;
    start_weekday <= w;
    day_offset    <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_dates.push_back(shift_date(y, m, d, w, off));
  endtask

  // hold out_ready low for a drawn number of cycles once each beat shows up
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall == 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        repeat (stall - 1) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    shifted_date_t got;
    shifted_date_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{new_year, new_month, new_day, new_weekday, out_of_range};
      if (pending_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected beat: %0d-%0d-%0d wd %0d oor %0d",
                   got.year, got.month, got.day, got.weekday, got.out_of_range);
        end
      end else begin
        want = pending_dates.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"mismatch: expected %0d-%0d-%0d wd %0d oor %0d,",
                      " got %0d-%0d-%0d wd %0d oor %0d"},
                     want.year, want.month, want.day, want.weekday, want.out_of_range,
                     got.year, got.month, got.day, got.weekday, got.out_of_range);
          end
        end
      end
    end
  end

  task automatic test_zero_offset_normalize();
    send_date(2023, 4, 31, 3, 0);
    send_date(2023, 2, 29, 1, 0);
    send_date(2024, 2, 29, 5, 0);
    send_date(2024, 3, 0, 2, 0);
    send_date(2023, 12, 31, 7, 0);
  endtask

  task automatic test_month_codes();
    send_date(2020, 0, 15, 4, 10);
    send_date(2020, 13, 15, 4, -10);
    send_date(2020, 14, 28, 4, 1);
    send_date(2020, 15, 31, 4, 0);
  endtask

  task automatic test_weekday_codes();
    send_date(2000, 6, 1, 0, 1);
    send_date(2000, 6, 1, 7, -1);
    send_date(2000, 6, 1, 1, -8);
  endtask

  task automatic test_leap_rules();
    send_date(100, 2, 28, 1, 1);
    send_date(4, 3, 1, 2, -1);
    send_date(2023, 2, 28, 3, 1);
    send_date(2000, 1, 31, 4, 29);
  endtask

  task automatic test_offset_extremes();
    send_date(5000, 7, 15, 3, 32767);
    send_date(5000, 7, 15, 3, -32768);
    send_date(1, 1, 1, 1, -1);
    send_date(9999, 12, 31, 7, 1);
    send_date(0, 6, 10, 2, 0);
    send_date(16383, 1, 1, 1, -32768);
    send_date(3, 1, 1, 1, -32768);
    send_date(9998, 1, 1, 1, 32767);
  endtask

  task automatic test_random_dates();
    int yr;
    int mo;
    int dy;
    int pick;
    for (int i = 0; i < 900; i++) begin
      if (i % 75 == 0) begin
        steady = (i == 75) || ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        yr = $urandom_range(1, 40);
      end else if (pick == 1) begin
        yr = $urandom_range(9960, 9999);
      end else begin
        yr = $urandom_range(1, 9999);
      end
      mo = $urandom_range(1, 12);
      if ($urandom_range(0, 9) != 0) begin
        dy = $urandom_range(1, days_in_month(mo - 1, yr));
      end else begin
        dy = $urandom_range(28, 31);
      end
      send_date(YEAR_W'(yr), MONTH_W'(mo), DAY_W'(dy), WDAY_W'($urandom_range(1, 7)),
                draw_offset());
    end
    steady = 1'b0;
  endtask

  task automatic test_random_fields();
    for (int i = 0; i < 150; i++) begin
      send_date(YEAR_W'($urandom_range(0, 16383)), MONTH_W'($urandom_range(0, 15)),
                DAY_W'($urandom_range(0, 31)), WDAY_W'($urandom_range(0, 7)),
                draw_offset());
    end
  endtask

  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    start_year     <= '0;
    start_month    <= '0;
    start_day      <= '0;
    start_weekday  <= '0;
    day_offset     <= '0;
    mismatch_count = 0;
    steady         = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_offset_normalize();
    test_month_codes();
    test_weekday_codes();
    test_leap_rules();
    test_offset_extremes();
    test_random_dates();
    test_random_fields();

    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: calendar_day_offset_adder_unit.f
+incdir+hdl
hdl/cdoa_pkg.sv
hdl/calendar_day_offset_adder_unit.sv
bench/testbench.sv
